@@ rtl/priority_interrupt_dispatch_macros.svh @@
// Assertion macros shared by the interrupt dispatch RTL.
`ifndef PRIORITY_INTERRUPT_DISPATCH_MACROS_SVH
`define PRIORITY_INTERRUPT_DISPATCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pid_pkg.sv @@
// Shared constants and types for the priority interrupt dispatch block.
package pid_pkg;

	localparam int PEND_W   = 16;
	localparam int LINE_W   = 4;
	localparam int LEVEL_W  = 4;
	localparam int KIND_W   = 2;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;
	localparam int KEY_W    = 1 + LEVEL_W + LINE_W;

	localparam int LINES_DEF        = 16;
	localparam int SWITCH_LINE_DEF  = 15;
	localparam int SWITCH_LEVEL_DEF = 7;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_RAISE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TIMER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IO    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd3;

	// Register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_LINE_LEVELS   = 2'd0;
	localparam logic [1:0] REG_TIMER_LINES   = 2'd1;
	localparam logic [1:0] REG_IO_LINES      = 2'd2;
	localparam logic [1:0] REG_HANDLER_LINES = 2'd3;

	typedef struct packed {
		logic               claimed;
		logic [LINE_W-1:0]  claimed_line;
		logic [LEVEL_W-1:0] claimed_level;
		logic               runs_handler;
		logic               is_switch;
		logic [PEND_W-1:0]  pending_after;
	} result_t;

endpackage

@@ rtl/priority_interrupt_dispatch.sv @@
// Priority interrupt dispatch: pend lines, then claim the best unmasked one.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one event beat: kind selects
//   a single-line raise, a timer-class raise, an I/O-class raise or a bare
//   claim; current_level is the running priority (0 masks nothing) and masked
//   suppresses the claim. Every request beat yields exactly one response beat
//   on rsp_valid/rsp_ready with the claimed line, its level, handler/switch
//   flags and the pending bits left behind.
//   Path: a taken beat is registered in the input stage, then in the response
//   register that drives the response port. Throughput: one beat per cycle
//   while rsp_ready is not held low, set by the single pass of
//   pend-merge, 16-way min-level tree and pending update between the input
//   stage and the response register.
//   Stall: when the receiver holds rsp_ready low, the response register holds,
//   the input stage fills once more and req_ready drops until space frees.
//   Reset: pending bits, all configuration registers and both valid flags
//   clear. Configuration is written over the APB port (64-bit data, register
//   i at byte address 8*i); pready is always high.
module priority_interrupt_dispatch #(
	parameter int LINES        = pid_pkg::LINES_DEF,
	parameter int SWITCH_LINE  = pid_pkg::SWITCH_LINE_DEF,
	parameter int SWITCH_LEVEL = pid_pkg::SWITCH_LEVEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pid_pkg::ADDR_W-1:0]  paddr,
	input  logic [pid_pkg::DATA_W-1:0]  pwdata,
	output logic [pid_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [pid_pkg::KIND_W-1:0]  kind,
	input  logic [pid_pkg::LINE_W-1:0]  line,
	input  logic [pid_pkg::LEVEL_W-1:0] current_level,
	input  logic                        masked,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        claimed,
	output logic [pid_pkg::LINE_W-1:0]  claimed_line,
	output logic [pid_pkg::LEVEL_W-1:0] claimed_level,
	output logic                        runs_handler,
	output logic                        is_switch,
	output logic [pid_pkg::PEND_W-1:0]  pending_after
);

`include "priority_interrupt_dispatch_macros.svh"

	localparam int PW = pid_pkg::PEND_W;
	localparam int LW = pid_pkg::LINE_W;
	localparam int VW = pid_pkg::LEVEL_W;
	localparam int KW = pid_pkg::KEY_W;
	// Only lines below both LINES and the pending width exist.
	localparam int NL = (LINES > PW) ? PW : LINES;
	localparam logic [PW-1:0] LINE_MASK = PW'((64'd1 << NL) - 64'd1);
	localparam int TREE_D = $clog2(PW);

	// Configuration registers
	logic [pid_pkg::DATA_W-1:0] line_levels_q;
	logic [PW-1:0]              timer_lines_q;
	logic [PW-1:0]              io_lines_q;
	logic [PW-1:0]              handler_lines_q;

	// Input stage
	logic                s1_valid_s1;
	logic [pid_pkg::KIND_W-1:0] kind_s1;
	logic [LW-1:0]       line_s1;
	logic [VW-1:0]       cur_s1;
	logic                masked_s1;

	// Pending state and response register
	logic [PW-1:0]       pending_q;
	logic                rsp_valid_q;
	pid_pkg::result_t    rsp_q;

	logic                cfg_wr;
	logic [1:0]          cfg_idx;
	logic                advance;

	logic [PW-1:0]       raise;
	logic [PW-1:0]       merged;
	logic [KW-1:0]       node [0:TREE_D][0:PW-1];
	logic [VW-1:0]       lvl;
	logic                elig;
	logic [KW-1:0]       winner;
	logic                found;
	logic [LW-1:0]       best;
	logic                sw;
	pid_pkg::result_t    res;

	// ---------------------------------------------------------------
	// APB configuration: write on the access phase, decode on 8-byte slots.
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_levels_q   <= '0;
			timer_lines_q   <= '0;
			io_lines_q      <= '0;
			handler_lines_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pid_pkg::REG_LINE_LEVELS:   line_levels_q   <= pwdata;
				pid_pkg::REG_TIMER_LINES:   timer_lines_q   <= pwdata[PW-1:0];
				pid_pkg::REG_IO_LINES:      io_lines_q      <= pwdata[PW-1:0];
				pid_pkg::REG_HANDLER_LINES: handler_lines_q <= pwdata[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pid_pkg::REG_LINE_LEVELS:   prdata = line_levels_q;
			pid_pkg::REG_TIMER_LINES:   prdata = pid_pkg::DATA_W'(timer_lines_q);
			pid_pkg::REG_IO_LINES:      prdata = pid_pkg::DATA_W'(io_lines_q);
			pid_pkg::REG_HANDLER_LINES: prdata = pid_pkg::DATA_W'(handler_lines_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: the input stage drains into the response register whenever
	// that register is empty or being taken this cycle.
	// ---------------------------------------------------------------
	assign advance   = s1_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			s1_valid_s1 <= req_valid;
		end
	end

	// Payload of the input stage needs no reset.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1   <= kind;
			line_s1   <= line;
			cur_s1    <= current_level;
			masked_s1 <= masked;
		end
	end

	// ---------------------------------------------------------------
	// Pend: merge the event into the pending bits, drop absent lines.
	// ---------------------------------------------------------------
	always_comb begin
		raise = '0;
		case (kind_s1)
			pid_pkg::KIND_RAISE: begin
				if (int'(line_s1) < NL)
					raise = PW'(1) << line_s1;
			end
			pid_pkg::KIND_TIMER: raise = timer_lines_q;
			pid_pkg::KIND_IO:    raise = io_lines_q;
			default:             raise = '0;
		endcase
		merged = (pending_q | raise) & LINE_MASK;
	end

	// ---------------------------------------------------------------
	// Claim: key = {not eligible, level, index}; the smallest key wins, so
	// the lowest level takes it and ties go to the lowest index.
	// ---------------------------------------------------------------
	always_comb begin
		for (int r = 0; r <= TREE_D; r++)
			for (int j = 0; j < PW; j++)
				node[r][j] = '1;
		for (int i = 0; i < PW; i++) begin
			lvl  = (i == SWITCH_LINE) ? VW'(SWITCH_LEVEL) : line_levels_q[VW*i +: VW];
			elig = merged[i] && !masked_s1 && ((cur_s1 == '0) || (lvl < cur_s1));
			node[0][i] = {!elig, lvl, LW'(i)};
		end
		for (int r = 0; r < TREE_D; r++)
			for (int j = 0; j < (PW >> (r + 1)); j++)
				node[r+1][j] = (node[r][2*j] <= node[r][2*j+1]) ?
					node[r][2*j] : node[r][2*j+1];
		winner = node[TREE_D][0];
	end

	assign found = !winner[KW-1];
	assign best  = winner[LW-1:0];
	// A switch line outside the existing lines is never pending, so never matches.
	assign sw    = found && (int'(best) == SWITCH_LINE);

	always_comb begin
		res = '0;
		if (found) begin
			res.claimed       = 1'b1;
			res.claimed_line  = best;
			res.claimed_level = winner[LW +: VW];
			res.runs_handler  = !sw && handler_lines_q[best];
			res.is_switch     = sw;
			res.pending_after = merged & ~(PW'(1) << best);
		end else begin
			res.pending_after = merged;
		end
	end

	// ---------------------------------------------------------------
	// Commit: pending state and response register advance together.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance)
				pending_q <= res.pending_after;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= res;
	end

	assign rsp_valid     = rsp_valid_q;
	assign claimed       = rsp_q.claimed;
	assign claimed_line  = rsp_q.claimed_line;
	assign claimed_level = rsp_q.claimed_level;
	assign runs_handler  = rsp_q.runs_handler;
	assign is_switch     = rsp_q.is_switch;
	assign pending_after = rsp_q.pending_after;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`PID_ASSERT_NOW(a_claim_clears, clk, arst_n, rsp_valid_q && rsp_q.claimed, !rsp_q.pending_after[rsp_q.claimed_line], "claimed line still pending")
	`PID_ASSERT_NEXT(a_state_tracks_rsp, clk, arst_n, advance, (pending_q == rsp_q.pending_after) && rsp_valid_q, "pending state differs from last response")
	`PID_ASSERT_NOW(a_switch_no_handler, clk, arst_n, rsp_valid_q && rsp_q.is_switch, rsp_q.claimed && !rsp_q.runs_handler, "switch claim reports a handler")
	`PID_ASSERT_NOW(a_no_claim_zero, clk, arst_n, rsp_valid_q && !rsp_q.claimed, (rsp_q.claimed_line == '0) && (rsp_q.claimed_level == '0) && !rsp_q.is_switch, "empty claim carries data")

endmodule
